>>> sv/y2rgb_pkg.sv
// Constants and helpers shared by the 4:2:0 to 15-bit RGB pixel converter.
`timescale 1ns / 1ps

package y2rgb_pkg;

   // Luma gain and rounding of the final fixed-point scaling (16 fraction bits).
   localparam int LumaGain  = 76309;
   localparam int HalfGain  = LumaGain / 2;
   localparam int RoundBias = 32768;
   localparam int LumaBlack = 16;
   localparam int ChanMax   = 31;

   // Chroma coefficient magnitudes; signs are applied when offsets are formed.
   localparam int CoefRv = 104597;
   localparam int CoefGu = 25675;
   localparam int CoefGv = 53279;
   localparam int CoefBu = 132201;

   // Offset terms, in the order they travel down the pipeline.
   localparam int TermRv    = 0;
   localparam int TermGu    = 1;
   localparam int TermGv    = 2;
   localparam int TermBu    = 3;
   localparam int NumTerms  = 4;

   // Color channels of one pixel.
   localparam int ChanRed   = 0;
   localparam int ChanGreen = 1;
   localparam int ChanBlue  = 2;
   localparam int NumChans  = 3;
   localparam int NumPixels = 4;

   // Widths of the datapath.
   localparam int LumaWidth  = 8;
   localparam int MagWidth   = 8;   // |chroma - 128|, up to 128
   localparam int NumWidth   = 25;  // coefficient * magnitude + half gain
   localparam int QuoWidth   = 8;   // rounded offset magnitude, up to 222
   localparam int OffWidth   = 10;  // signed offset
   localparam int SumWidth   = 11;  // signed luma + offset - black level
   localparam int ProdWidth  = 30;  // signed scaled sum plus bias
   localparam int ChanWidth  = 5;
   localparam int ShiftWidth = 2;
   localparam int PixWidth   = 16;

   // Reciprocal of the luma gain; exact floor division for numerators below 2^31.
   localparam int RecipShift = 44;
   localparam int RecipWidth = 28;
   localparam longint unsigned RecipFull =
      ((64'd1 << RecipShift) + 64'(LumaGain) - 64'd1) / 64'(LumaGain);
   localparam logic [RecipWidth-1:0] RecipMul = RecipFull[RecipWidth-1:0];

   localparam logic [ShiftWidth-1:0] ShiftReset = 2'd2;

   typedef logic [NumWidth+RecipWidth-1:0] recip_prod_type;

   // floor(num / LumaGain) through the reciprocal multiply.
   function automatic logic [QuoWidth-1:0] div_gain(input logic [NumWidth-1:0] num);
      recip_prod_type p;
      p = recip_prod_type'(num) * recip_prod_type'(RecipMul);
      return p[RecipShift +: QuoWidth];
   endfunction

endpackage

>>> sv/yuv420_to_rgb15_pixel_converter.sv
// Top level: pipelined 2x2-block YUV 4:2:0 to 15-bit RGB pixel converter.
`timescale 1ns / 1ps

//  channel   ports                          direction  content
//  request   req_valid/req_ready + 6 fields in         four luma, one U,V pair
//  response  rsp_valid/rsp_ready + 4 fields out        four packed 16-bit pixels
//  csr       csr_write_enable/csr_write_data in        channel shift, reset 2
//
//  Five register stages; response valid is the valid bit of the last stage, and a
//  new block can enter every cycle while rsp_ready does not stall the response.
//  Stage depth is set by the reciprocal multiply that forms the rounded chroma
//  offsets.
//  Each stage holds its own valid bit and advances whenever it is empty or the
//  stage after it advances, so bubbles collapse and a stall drops nothing.
//  Synchronous reset clears the valid bits and sets the channel shift to 2.

module yuv420_to_rgb15_pixel_converter (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_luma_top_left,
   input  logic [7:0]  req_luma_top_right,
   input  logic [7:0]  req_luma_bottom_left,
   input  logic [7:0]  req_luma_bottom_right,
   input  logic [7:0]  req_chroma_blue,
   input  logic [7:0]  req_chroma_red,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_top_left,
   output logic [15:0] rsp_pixel_top_right,
   output logic [15:0] rsp_pixel_bottom_left,
   output logic [15:0] rsp_pixel_bottom_right,
   // configuration
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   localparam int Np = y2rgb_pkg::NumPixels;
   localparam int Nt = y2rgb_pkg::NumTerms;
   localparam int Nc = y2rgb_pkg::NumChans;

   // ---------------------------------------------------------------------
   // Channel shift register
   // ---------------------------------------------------------------------
   logic [y2rgb_pkg::ShiftWidth-1:0] shift_ff, shift_in;

   always_comb begin
      shift_in = shift_ff;
      if (csr_write_enable) begin
         shift_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= y2rgb_pkg::ShiftReset;
      end else begin
         shift_ff <= shift_in;
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: a stage advances when it is empty or its successor moves.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;
   assign rsp_valid = v5_ff;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;
   assign v5_in = en5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: chroma magnitudes times coefficients, plus half gain for
   // round-half-away-from-zero. The sign of each term travels separately.
   // ---------------------------------------------------------------------
   logic [y2rgb_pkg::LumaWidth-1:0] luma [Np];
   logic [y2rgb_pkg::MagWidth-1:0]  mag_u, mag_v;
   logic                            neg_u, neg_v;

   logic [y2rgb_pkg::LumaWidth-1:0] y1_ff   [Np];
   logic [y2rgb_pkg::NumWidth-1:0]  num1_ff [Nt];
   logic [y2rgb_pkg::NumWidth-1:0]  num1_in [Nt];
   logic                            neg1_ff [Nt];
   logic                            neg1_in [Nt];

   assign luma[0] = req_luma_top_left;
   assign luma[1] = req_luma_top_right;
   assign luma[2] = req_luma_bottom_left;
   assign luma[3] = req_luma_bottom_right;

   // Top bit set means the sample is at or above 128: magnitude is the low bits.
   assign neg_u = !req_chroma_blue[7];
   assign neg_v = !req_chroma_red[7];
   assign mag_u = neg_u ? y2rgb_pkg::MagWidth'(9'd128 - {1'b0, req_chroma_blue})
                        : {1'b0, req_chroma_blue[6:0]};
   assign mag_v = neg_v ? y2rgb_pkg::MagWidth'(9'd128 - {1'b0, req_chroma_red})
                        : {1'b0, req_chroma_red[6:0]};

   always_comb begin
      num1_in[y2rgb_pkg::TermRv] =
         y2rgb_pkg::NumWidth'(y2rgb_pkg::CoefRv) * y2rgb_pkg::NumWidth'(mag_v)
         + y2rgb_pkg::NumWidth'(y2rgb_pkg::HalfGain);
      num1_in[y2rgb_pkg::TermGu] =
         y2rgb_pkg::NumWidth'(y2rgb_pkg::CoefGu) * y2rgb_pkg::NumWidth'(mag_u)
         + y2rgb_pkg::NumWidth'(y2rgb_pkg::HalfGain);
      num1_in[y2rgb_pkg::TermGv] =
         y2rgb_pkg::NumWidth'(y2rgb_pkg::CoefGv) * y2rgb_pkg::NumWidth'(mag_v)
         + y2rgb_pkg::NumWidth'(y2rgb_pkg::HalfGain);
      num1_in[y2rgb_pkg::TermBu] =
         y2rgb_pkg::NumWidth'(y2rgb_pkg::CoefBu) * y2rgb_pkg::NumWidth'(mag_u)
         + y2rgb_pkg::NumWidth'(y2rgb_pkg::HalfGain);
      // Green coefficients are negative, so their terms flip sign.
      neg1_in[y2rgb_pkg::TermRv] = neg_v;
      neg1_in[y2rgb_pkg::TermGu] = !neg_u;
      neg1_in[y2rgb_pkg::TermGv] = !neg_v;
      neg1_in[y2rgb_pkg::TermBu] = neg_u;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         y1_ff   <= luma;
         num1_ff <= num1_in;
         neg1_ff <= neg1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: divide by the luma gain through the reciprocal multiply.
   // ---------------------------------------------------------------------
   logic [y2rgb_pkg::LumaWidth-1:0] y2_ff   [Np];
   logic [y2rgb_pkg::QuoWidth-1:0]  quo2_ff [Nt];
   logic [y2rgb_pkg::QuoWidth-1:0]  quo2_in [Nt];
   logic                            neg2_ff [Nt];

   always_comb begin
      for (int i = 0; i < Nt; i++) begin
         quo2_in[i] = y2rgb_pkg::div_gain(num1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         y2_ff   <= y1_ff;
         quo2_ff <= quo2_in;
         neg2_ff <= neg1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: signed offsets, then luma + offset - black level per channel.
   // ---------------------------------------------------------------------
   logic signed [y2rgb_pkg::OffWidth-1:0] term [Nt];
   logic signed [y2rgb_pkg::OffWidth-1:0] off  [Nc];
   logic signed [y2rgb_pkg::SumWidth-1:0] sum3_ff [Np][Nc];
   logic signed [y2rgb_pkg::SumWidth-1:0] sum3_in [Np][Nc];

   always_comb begin
      for (int i = 0; i < Nt; i++) begin
         term[i] = neg2_ff[i]
                   ? -$signed(y2rgb_pkg::OffWidth'(quo2_ff[i]))
                   :  $signed(y2rgb_pkg::OffWidth'(quo2_ff[i]));
      end
      off[y2rgb_pkg::ChanRed]   = term[y2rgb_pkg::TermRv];
      off[y2rgb_pkg::ChanGreen] = term[y2rgb_pkg::TermGu] + term[y2rgb_pkg::TermGv];
      off[y2rgb_pkg::ChanBlue]  = term[y2rgb_pkg::TermBu];
      for (int p = 0; p < Np; p++) begin
         for (int c = 0; c < Nc; c++) begin
            sum3_in[p][c] = $signed(y2rgb_pkg::SumWidth'(y2_ff[p]))
                            + y2rgb_pkg::SumWidth'(off[c])
                            - $signed(y2rgb_pkg::SumWidth'(y2rgb_pkg::LumaBlack));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sum3_ff <= sum3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: scale by the luma gain and add the rounding bias.
   // ---------------------------------------------------------------------
   logic signed [y2rgb_pkg::ProdWidth-1:0] prod4_ff [Np][Nc];
   logic signed [y2rgb_pkg::ProdWidth-1:0] prod4_in [Np][Nc];

   always_comb begin
      for (int p = 0; p < Np; p++) begin
         for (int c = 0; c < Nc; c++) begin
            prod4_in[p][c] = y2rgb_pkg::ProdWidth'(sum3_ff[p][c])
                             * $signed(y2rgb_pkg::ProdWidth'(y2rgb_pkg::LumaGain))
                             + $signed(y2rgb_pkg::ProdWidth'(y2rgb_pkg::RoundBias));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         prod4_ff <= prod4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: clamp to 0..255, shift, saturate at 31 and pack the pixel.
   // ---------------------------------------------------------------------
   logic [y2rgb_pkg::PixWidth-1:0]  pix5_ff [Np];
   logic [y2rgb_pkg::PixWidth-1:0]  pix5_in [Np];
   logic [y2rgb_pkg::ChanWidth-1:0] chan [Np][Nc];
   logic [7:0]                      clamped [Np][Nc];
   logic [7:0]                      shifted [Np][Nc];

   always_comb begin
      for (int p = 0; p < Np; p++) begin
         for (int c = 0; c < Nc; c++) begin
            if (prod4_ff[p][c] < 0) begin
               clamped[p][c] = 8'd0;
            end else if (|prod4_ff[p][c][y2rgb_pkg::ProdWidth-1:24]) begin
               clamped[p][c] = 8'd255;
            end else begin
               clamped[p][c] = prod4_ff[p][c][23:16];
            end
            shifted[p][c] = clamped[p][c] >> shift_ff;
            chan[p][c] = (shifted[p][c] > 8'(y2rgb_pkg::ChanMax))
                         ? y2rgb_pkg::ChanWidth'(y2rgb_pkg::ChanMax)
                         : shifted[p][c][y2rgb_pkg::ChanWidth-1:0];
         end
         pix5_in[p] = {1'b1, chan[p][y2rgb_pkg::ChanBlue],
                       chan[p][y2rgb_pkg::ChanGreen], chan[p][y2rgb_pkg::ChanRed]};
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         pix5_ff <= pix5_in;
      end
   end

   assign rsp_pixel_top_left     = pix5_ff[0];
   assign rsp_pixel_top_right    = pix5_ff[1];
   assign rsp_pixel_bottom_left  = pix5_ff[2];
   assign rsp_pixel_bottom_right = pix5_ff[3];

endmodule
